// ===== src/winograd_weight_transform_3x3_core_defines.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef WINOGRAD_WEIGHT_TRANSFORM_3X3_CORE_DEFINES_SVH
`define WINOGRAD_WEIGHT_TRANSFORM_3X3_CORE_DEFINES_SVH
`define WWT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/wwt_pkg.sv =====
// Types and constants for the Winograd weight transform.
// No dependencies.
package wwt_pkg;
  localparam int TapBits   = 16;
  localparam int CoeffBits = 26;

  localparam logic [1:0] CFG_ADDR_TILE_MODE = 2'd0;

  typedef struct packed {
    logic signed [TapBits-1:0] tap_r0_c0;
    logic signed [TapBits-1:0] tap_r0_c1;
    logic signed [TapBits-1:0] tap_r0_c2;
    logic signed [TapBits-1:0] tap_r1_c0;
    logic signed [TapBits-1:0] tap_r1_c1;
    logic signed [TapBits-1:0] tap_r1_c2;
    logic signed [TapBits-1:0] tap_r2_c0;
    logic signed [TapBits-1:0] tap_r2_c1;
    logic signed [TapBits-1:0] tap_r2_c2;
  } in_item_t;

  typedef struct packed {
    logic signed [CoeffBits-1:0] coeff_value;
    logic [2:0]                  out_row;
    logic [2:0]                  out_col;
    logic                        last_of_tile;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     big;
  } job_t;

  // numerators of G, 4x4 over 2, 5x5 over 6
  function automatic logic signed [3:0] g_num(input logic big, input logic [2:0] i,
                                              input logic [1:0] a);
    logic signed [3:0] v;
    v = 4'sd0;
    if (!big) begin
      case ({i, a})
        {3'd0, 2'd0}: v = 4'sd2;
        {3'd1, 2'd0}: v = 4'sd1;
        {3'd1, 2'd1}: v = -4'sd1;
        {3'd1, 2'd2}: v = 4'sd1;
        {3'd2, 2'd0}: v = 4'sd1;
        {3'd2, 2'd1}: v = 4'sd1;
        {3'd2, 2'd2}: v = 4'sd1;
        {3'd3, 2'd2}: v = 4'sd2;
        default: v = 4'sd0;
      endcase
    end else begin
      case ({i, a})
        {3'd0, 2'd0}: v = 4'sd3;
        {3'd1, 2'd0}: v = -4'sd1;
        {3'd1, 2'd1}: v = 4'sd1;
        {3'd1, 2'd2}: v = -4'sd1;
        {3'd2, 2'd0}: v = -4'sd3;
        {3'd2, 2'd1}: v = -4'sd3;
        {3'd2, 2'd2}: v = -4'sd3;
        {3'd3, 2'd0}: v = 4'sd1;
        {3'd3, 2'd1}: v = 4'sd2;
        {3'd3, 2'd2}: v = 4'sd4;
        {3'd4, 2'd2}: v = 4'sd6;
        default: v = 4'sd0;
      endcase
    end
    return v;
  endfunction
endpackage

// ===== src/winograd_weight_transform_3x3_core.sv =====
// Coefficients are offered one per cycle while out_ready does not stall the output.
// Each tile yields 16 coefficients in 4x4 mode and 25 in 5x5 mode.
// Per coefficient: row combination, column combination, scaling and reciprocal
// multiply, divide-by-36 correction (5x5) or shift by two (4x4) into the output register.
// Reset: rst_n synchronous, active low; clears tile_mode, pipeline valids and queue.
// Top level: front end, two-entry queue, back end. Depends on wwt_pkg.
module winograd_weight_transform_3x3_core #(
  parameter int EXTRA_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wwt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wwt_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  wwt_pkg::job_t fq_data, qb_data;

  wwt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  wwt_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  wwt_back #(.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ===== src/wwt_front.sv =====
// Front end: APB mode register, input accept and tagging with tile mode.
// Depends on wwt_pkg.
module wwt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wwt_pkg::in_item_t  in_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output logic               q_valid,
  input  logic               q_ready,
  output wwt_pkg::job_t      q_data
);
  logic tile_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == wwt_pkg::CFG_ADDR_TILE_MODE) begin
      tile_mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == wwt_pkg::CFG_ADDR_TILE_MODE) ?
                      {31'd0, tile_mode_r} : 32'd0;

  assign q_valid     = in_valid;
  assign in_ready    = q_ready;
  assign q_data.item = in_data;
  assign q_data.big  = tile_mode_r;
endmodule

// ===== src/wwt_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on wwt_pkg.
module wwt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  wwt_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output wwt_pkg::job_t rd_data
);
  wwt_pkg::job_t mem_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) wptr_r <= ~wptr_r;
      if (rd_en) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

// ===== src/wwt_back.sv =====
// Back end: walks the output tile, row sums, column sum, rounding, output register.
// Depends on wwt_pkg.
module wwt_back #(
  parameter int EXTRA_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  wwt_pkg::job_t      q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wwt_pkg::out_item_t out_data
);
  localparam int TapBits    = wwt_pkg::TapBits;
  localparam int RowBits    = TapBits + 6;
  localparam int FullBits   = TapBits + 12;
  localparam int ScBits     = FullBits + EXTRA_FRAC_BITS + 1;
  localparam int RecipShift = TapBits + EXTRA_FRAC_BITS + 7;
  localparam int RecipBits  = RecipShift - 5;
  localparam logic [RecipBits-1:0] Recip =
    RecipBits'((64'd1 << RecipShift) / 64'd36);
  localparam int MulBits    = RecipShift + RecipBits;

  logic [2:0] i_r, j_r;
  logic       big;
  logic [2:0] nmax;
  logic       adv, last_ij;

  // stage 1 registers
  logic                      s1_valid_r;
  logic signed [RowBits-1:0] s1_row_r [3];
  logic [2:0]                s1_i_r, s1_j_r;
  logic                      s1_big_r, s1_last_r;
  // stage 2 registers
  logic                       s2_valid_r;
  logic signed [FullBits-1:0] s2_sum_r;
  logic [2:0]                 s2_i_r, s2_j_r;
  logic                       s2_big_r, s2_last_r;
  // stage 3 registers
  logic                     s3_valid_r;
  logic                     s3_neg_r, s3_big_r, s3_last_r;
  logic [MulBits-1:0]       s3_prod_r;
  logic [ScBits-1:0]        s3_num_r;
  logic [2:0]               s3_i_r, s3_j_r;

  logic out_valid_r;
  wwt_pkg::out_item_t out_r;
  logic stall;

  logic signed [TapBits-1:0]  f [3][3];
  logic signed [RowBits-1:0]  row_nxt [3];
  logic signed [FullBits-1:0] sum_nxt;
  logic [FullBits-1:0]        mag;
  logic [ScBits-1:0]          num_nxt;
  logic [ScBits-1:0]          q;
  logic [ScBits-1:0]          qc;
  logic [ScBits:0]            rem;

  assign big  = q_data.big;
  assign nmax = big ? 3'd4 : 3'd3;
  assign stall = out_valid_r && !out_ready;
  assign adv   = q_valid && !stall;
  assign last_ij = (i_r == nmax) && (j_r == nmax);
  assign q_ready = adv && last_ij;

  always_comb begin
    f[0][0] = q_data.item.tap_r0_c0;
    f[0][1] = q_data.item.tap_r0_c1;
    f[0][2] = q_data.item.tap_r0_c2;
    f[1][0] = q_data.item.tap_r1_c0;
    f[1][1] = q_data.item.tap_r1_c1;
    f[1][2] = q_data.item.tap_r1_c2;
    f[2][0] = q_data.item.tap_r2_c0;
    f[2][1] = q_data.item.tap_r2_c1;
    f[2][2] = q_data.item.tap_r2_c2;
    for (int b = 0; b < 3; b++) begin
      row_nxt[b] = RowBits'(wwt_pkg::g_num(big, i_r, 2'd0)) * RowBits'(f[0][b])
                 + RowBits'(wwt_pkg::g_num(big, i_r, 2'd1)) * RowBits'(f[1][b])
                 + RowBits'(wwt_pkg::g_num(big, i_r, 2'd2)) * RowBits'(f[2][b]);
    end
    sum_nxt = FullBits'(wwt_pkg::g_num(s1_big_r, s1_j_r, 2'd0)) * FullBits'(s1_row_r[0])
            + FullBits'(wwt_pkg::g_num(s1_big_r, s1_j_r, 2'd1)) * FullBits'(s1_row_r[1])
            + FullBits'(wwt_pkg::g_num(s1_big_r, s1_j_r, 2'd2)) * FullBits'(s1_row_r[2]);
    mag = s2_sum_r[FullBits-1] ? FullBits'(-s2_sum_r) : FullBits'(s2_sum_r);
    num_nxt = (ScBits'(mag) << EXTRA_FRAC_BITS)
            + (s2_big_r ? ScBits'(18) : ScBits'(2));
    // divide by 36 via floor reciprocal, low by at most one, then correct
    q   = ScBits'(s3_prod_r >> RecipShift);
    rem = {1'b0, s3_num_r} - (ScBits+1)'(q) * (ScBits+1)'(36);
    qc  = q;
    if (rem >= (ScBits+1)'(72)) qc = q + ScBits'(2);
    else if (rem >= (ScBits+1)'(36)) qc = q + ScBits'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= 3'd0;
      j_r <= 3'd0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      if (adv) begin
        if (j_r == nmax) begin
          j_r <= 3'd0;
          i_r <= last_ij ? 3'd0 : i_r + 3'd1;
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      s1_valid_r  <= adv;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_row_r  <= row_nxt;
      s1_i_r    <= i_r;
      s1_j_r    <= j_r;
      s1_big_r  <= big;
      s1_last_r <= last_ij;
      s2_sum_r  <= sum_nxt;
      s2_i_r    <= s1_i_r;
      s2_j_r    <= s1_j_r;
      s2_big_r  <= s1_big_r;
      s2_last_r <= s1_last_r;
      s3_num_r  <= num_nxt;
      s3_prod_r <= MulBits'(RecipShift'(num_nxt)) * MulBits'(Recip);
      s3_neg_r  <= s2_sum_r[FullBits-1];
      s3_big_r  <= s2_big_r;
      s3_i_r    <= s2_i_r;
      s3_j_r    <= s2_j_r;
      s3_last_r <= s2_last_r;
      out_r.coeff_value <= wwt_pkg::CoeffBits'(s3_big_r ?
        (s3_neg_r ? -qc : qc) :
        (s3_neg_r ? -(s3_num_r >> 2) : (s3_num_r >> 2)));
      out_r.out_row      <= s3_i_r;
      out_r.out_col      <= s3_j_r;
      out_r.last_of_tile <= s3_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ===== src/wwt_checker.sv =====
// Port-level checks for the Winograd weight transform.
// Depends on wwt_pkg and the defines header.
`include "winograd_weight_transform_3x3_core_defines.svh"
module wwt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input wwt_pkg::out_item_t out_data,
  input logic               cfg_pready
);
  `WWT_ASSERT_IMPL(a_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid && $stable(out_data), "output dropped while stalled")
  `WWT_ASSERT_IMPL(a_last, clk, rst_n, out_valid && out_data.last_of_tile, out_data.out_row == out_data.out_col && (out_data.out_row == 3'd3 || out_data.out_row == 3'd4), "last flag off the corner")
  `WWT_ASSERT_IMPL(a_idx, clk, rst_n, out_valid, out_data.out_row <= 3'd4 && out_data.out_col <= 3'd4, "index out of range")
  `WWT_ASSERT_NEXT(a_rdy, clk, rst_n, 1'b1, cfg_pready, "pready low")
endmodule

bind winograd_weight_transform_3x3_core wwt_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_data, .cfg_pready
);

// ===== dv/winograd_weight_transform_3x3_core_tb.sv =====
// Testbench for the Winograd 3x3 filter transform: drives random and corner
// filter tiles, predicts each 4x4 or 5x5 coefficient and checks them in order.
// Depends on wwt_pkg and winograd_weight_transform_3x3_core.
`timescale 1ns / 1ps
module winograd_weight_transform_3x3_core_tb;
  localparam int ExtraFrac = 8;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_ready;
  wwt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wwt_pkg::out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  winograd_weight_transform_3x3_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  wwt_pkg::in_item_t tile_q[$];
  wwt_pkg::out_item_t coeff_q[$];
  logic mode_shadow;
  int errors = 0;
  int burst_left;
  int gap_left;
  int hold_cycles;
  bit hold_req;
  bit hold_done;
  bit drain_req;
  int stall_phase;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [63:0] round_coeff(input logic signed [63:0] s,
                                                     input logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (s < 0) ? -s : s;
    q = ((mag << ExtraFrac) + den / 2) / den;
    return (s < 0) ? -q : q;
  endfunction

  function automatic int g_coef(input logic big, input int i, input int a);
    int g4[4][3];
    int g5[5][3];
    g4 = '{'{2, 0, 0}, '{1, -1, 1}, '{1, 1, 1}, '{0, 0, 2}};
    g5 = '{'{3, 0, 0}, '{-1, 1, -1}, '{-3, -3, -3}, '{1, 2, 4}, '{0, 0, 6}};
    return big ? g5[i][a] : g4[i][a];
  endfunction

  task automatic predict_tile(input wwt_pkg::in_item_t t);
    logic signed [63:0] f[3][3];
    logic signed [63:0] s;
    wwt_pkg::out_item_t c;
    int n;
    f[0][0] = 64'(t.tap_r0_c0); f[0][1] = 64'(t.tap_r0_c1); f[0][2] = 64'(t.tap_r0_c2);
    f[1][0] = 64'(t.tap_r1_c0); f[1][1] = 64'(t.tap_r1_c1); f[1][2] = 64'(t.tap_r1_c2);
    f[2][0] = 64'(t.tap_r2_c0); f[2][1] = 64'(t.tap_r2_c1); f[2][2] = 64'(t.tap_r2_c2);
    n = mode_shadow ? 5 : 4;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        s = '0;
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++)
            s += g_coef(mode_shadow, i, a) * g_coef(mode_shadow, j, b) * f[a][b];
        c.coeff_value = wwt_pkg::CoeffBits'(round_coeff(s, mode_shadow ? 64'd36 : 64'd4));
        c.out_row = 3'(i);
        c.out_col = 3'(j);
        c.last_of_tile = (i == n - 1) && (j == n - 1);
        coeff_q.push_back(c);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_tile(in_data);
        void'(tile_q.pop_front());
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (drain_req || tile_q.size() == 0 ||
                   (in_valid && in_ready && tile_q.size() == 0)) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (burst_left == 0 && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(1, 40);
        burst_left <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b1;
        in_data <= tile_q[0];
        if (burst_left > 0) burst_left <= burst_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    wwt_pkg::out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (coeff_q.size() == 0) begin
          $error("unexpected transfer coeff_value=%0d", out_data.coeff_value);
          errors++;
        end else begin
          e = coeff_q.pop_front();
          if (out_data.coeff_value !== e.coeff_value) begin
            $error("coeff_value exp %0d got %0d", e.coeff_value, out_data.coeff_value);
            errors++;
          end
          if (out_data.out_row !== e.out_row) begin
            $error("out_row exp %0d got %0d", e.out_row, out_data.out_row);
            errors++;
          end
          if (out_data.out_col !== e.out_col) begin
            $error("out_col exp %0d got %0d", e.out_col, out_data.out_col);
            errors++;
          end
          if (out_data.last_of_tile !== e.last_of_tile) begin
            $error("last_of_tile exp %0d got %0d", e.last_of_tile, out_data.last_of_tile);
            errors++;
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_cycles <= 400;
        hold_done <= 1'b1;
      end else if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else if (stall_phase[9]) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic logic [15:0] rand_tap();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 7) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic wwt_pkg::in_item_t rand_tile();
    wwt_pkg::in_item_t t;
    t = {rand_tap(), rand_tap(), rand_tap(), rand_tap(), rand_tap(), rand_tap(),
         rand_tap(), rand_tap(), rand_tap()};
    return t;
  endfunction

  task automatic wait_idle();
    while (tile_q.size() != 0 || in_valid || coeff_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(input logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= wwt_pkg::CFG_ADDR_TILE_MODE;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    mode_shadow = v[0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  initial begin
    hold_req = 1'b0;
    drain_req = 0;
    mode_shadow = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int m = 0; m < 4; m++) begin
      if (m > 0) write_mode(m == 3 ? 32'hffff_fffe : ((m == 1) ? 32'h1 : 32'hffff_ffff));
      tile_q.push_back('0);
      tile_q.push_back({9{16'h7fff}});
      tile_q.push_back({9{16'h8000}});
      tile_q.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      tile_q.push_back({16'h0001, 16'hffff, 16'h0001, 16'h0002, 16'hfffe,
                        16'h0003, 16'hfffd, 16'h0005, 16'hfffb});
      wait_idle();
    end
    for (int p = 0; p < 6; p++) begin
      write_mode($urandom());
      for (int k = 0; k < 35; k++) tile_q.push_back(rand_tile());
      if (p == 2) hold_req = 1'b1;
      if (p == 4) begin
        while (tile_q.size() > 20) @(posedge clk);
        drain_req = 1;
        while (in_valid || coeff_q.size() != 0) @(posedge clk);
        drain_req = 0;
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== winograd_weight_transform_3x3_core.f =====
+incdir+src
src/wwt_pkg.sv
src/wwt_front.sv
src/wwt_queue.sv
src/wwt_back.sv
src/winograd_weight_transform_3x3_core.sv
src/wwt_checker.sv
dv/winograd_weight_transform_3x3_core_tb.sv
